// ----- src/base37_name_encoder_core_macros.svh -----
// assertion helpers shared by the encoder modules
// each module that uses them has i_clk and i_rst_n ports
`ifndef BASE37_NAME_ENCODER_CORE_MACROS_SVH
`define BASE37_NAME_ENCODER_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define B37_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define B37_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/b37_pkg.sv -----
package b37_pkg;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int VALUE_W = 63;
    localparam int COUNT_W = 4;

    // defaults for the top level parameters
    localparam int MAX_NAME_LENGTH_DEF = 12;
    localparam int QUEUE_DEPTH_DEF     = 2;

    // classified beat passed from front to back
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_beat;

endpackage

// ----- src/b37_front.sv -----
module b37_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [b37_pkg::CHAR_W-1:0] i_char_code,
    input  logic                       i_last_char,
    output logic                       o_valid,
    input  logic                       i_stall,
    output b37_pkg::t_beat             o_beat
);

    localparam logic [b37_pkg::CHAR_W-1:0] LOWER_A = 8'd97;
    localparam logic [b37_pkg::CHAR_W-1:0] UPPER_A = 8'd65;
    localparam logic [b37_pkg::CHAR_W-1:0] ZERO_CH = 8'd48;
    localparam logic [b37_pkg::CHAR_W-1:0] LETTER_BASE = 8'd1;
    localparam logic [b37_pkg::CHAR_W-1:0] NUMBER_BASE = 8'd27;

    logic                         r_valid;
    b37_pkg::t_beat               r_beat;
    b37_pkg::t_beat               n_beat;
    logic [b37_pkg::CHAR_W-1:0]   digit_wide;

    // hold the beat while the queue is full
    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    // clean the byte into its base-37 digit, zero for space and any other byte
    always_comb begin
        case (i_char_code) inside
            [8'd97:8'd122]: digit_wide = i_char_code - LOWER_A + LETTER_BASE;
            [8'd65:8'd90]:  digit_wide = i_char_code - UPPER_A + LETTER_BASE;
            [8'd48:8'd57]:  digit_wide = i_char_code - ZERO_CH + NUMBER_BASE;
            default:        digit_wide = '0;
        endcase
        n_beat.digit = digit_wide[b37_pkg::DIGIT_W-1:0];
        n_beat.last  = i_last_char;
    end

    // beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_beat <= n_beat;
        end
    end

endmodule

// ----- src/b37_queue.sv -----
`include "base37_name_encoder_core_macros.svh"

module b37_queue #(
    parameter int DEPTH = b37_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  b37_pkg::t_beat i_beat,
    output logic           o_valid,
    input  logic           i_stall,
    output b37_pkg::t_beat o_beat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b37_pkg::t_beat     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               push;
    logic               pop;

    assign o_stall = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd_ptr];
    assign push    = i_valid & ~o_stall;
    assign pop     = o_valid & ~i_stall;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

    `B37_ASSERT_ALWAYS(a_queue_bound, r_count <= FULL_CNT, "queue fill count above depth")

endmodule

// ----- src/b37_back.sv -----
`include "base37_name_encoder_core_macros.svh"

module b37_back #(
    parameter int MAX_NAME_LENGTH = b37_pkg::MAX_NAME_LENGTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  b37_pkg::t_beat              i_beat,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [b37_pkg::VALUE_W-1:0] o_packed_name,
    output logic [b37_pkg::COUNT_W-1:0] o_kept_length
);

    localparam logic [b37_pkg::COUNT_W-1:0] MAX_CNT = b37_pkg::COUNT_W'(MAX_NAME_LENGTH);

    logic [b37_pkg::VALUE_W-1:0] r_run;
    logic [b37_pkg::COUNT_W-1:0] r_cnt;
    logic [b37_pkg::VALUE_W-1:0] r_cmt_val;
    logic [b37_pkg::COUNT_W-1:0] r_cmt_cnt;
    logic [b37_pkg::VALUE_W-1:0] n_run;
    logic [b37_pkg::COUNT_W-1:0] n_cnt;
    logic [b37_pkg::VALUE_W-1:0] n_cmt_val;
    logic [b37_pkg::COUNT_W-1:0] n_cmt_cnt;
    logic                        r_out_valid;
    logic [b37_pkg::VALUE_W-1:0] r_out_name;
    logic [b37_pkg::COUNT_W-1:0] r_out_len;
    logic [b37_pkg::VALUE_W-1:0] step_val;
    logic [b37_pkg::COUNT_W-1:0] step_cnt;
    logic [b37_pkg::VALUE_W-1:0] times37;
    logic                        nonspace;
    logic                        take;

    // only a last beat waits for the result register
    assign o_stall  = i_valid & i_beat.last & r_out_valid & i_stall;
    assign take     = i_valid & ~o_stall;
    assign nonspace = (i_beat.digit != '0);

    // running value times 37 as shift-add
    assign times37 = (r_run << 5) + (r_run << 2) + r_run;

    // accumulate one character and track the last non-space
    always_comb begin
        step_val  = r_run;
        step_cnt  = r_cnt;
        n_cmt_val = r_cmt_val;
        n_cmt_cnt = r_cmt_cnt;
        if (r_cnt < MAX_CNT) begin
            if (nonspace || r_cnt != '0) begin
                step_val = times37 + b37_pkg::VALUE_W'(i_beat.digit);
                step_cnt = r_cnt + 1'b1;
            end
        end
        if (nonspace) begin
            n_cmt_val = step_val;
            n_cmt_cnt = step_cnt;
        end
        n_run = step_val;
        n_cnt = step_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= '0;
            r_cnt     <= '0;
            r_cmt_val <= '0;
            r_cmt_cnt <= '0;
        end else if (take) begin
            if (i_beat.last) begin
                r_run     <= '0;
                r_cnt     <= '0;
                r_cmt_val <= '0;
                r_cmt_cnt <= '0;
            end else begin
                r_run     <= n_run;
                r_cnt     <= n_cnt;
                r_cmt_val <= n_cmt_val;
                r_cmt_cnt <= n_cmt_cnt;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_beat.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_beat.last) begin
            r_out_name <= n_cmt_val;
            r_out_len  <= n_cmt_cnt;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_name = r_out_name;
    assign o_kept_length = r_out_len;

    `B37_ASSERT_ALWAYS(a_len_bound, !r_out_valid || r_out_len <= MAX_CNT, "kept length above limit")
    `B37_ASSERT_ALWAYS(a_cmt_le_cnt, r_cmt_cnt <= r_cnt, "committed count ahead of running count")
    `B37_ASSERT_NEXT(a_clear_after_last, take && i_beat.last, r_cnt == '0 && r_cmt_cnt == '0, "state not cleared after last beat")

endmodule

// ----- src/base37_name_encoder_core.sv -----
// a result passes the beat register, the queue and the result register after the last byte of a name is accepted
// throughput: one byte per cycle while nothing stalls; the accumulator folds one digit per cycle
// a stalled result holds back only a last byte at the back; bytes behind it wait in the queue
// reset: synchronous active-low i_rst_n clears the beat valid, the queue,
// the accumulator and the result valid; no clearing pass is needed
module base37_name_encoder_core #(
    parameter int MAX_NAME_LENGTH = b37_pkg::MAX_NAME_LENGTH_DEF,
    parameter int QUEUE_DEPTH     = b37_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [b37_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_last_char,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [b37_pkg::VALUE_W-1:0] o_packed_name,
    output logic [b37_pkg::COUNT_W-1:0] o_kept_length
);

    logic           front_valid;
    logic           front_stall;
    b37_pkg::t_beat front_beat;
    logic           queue_valid;
    logic           queue_stall;
    b37_pkg::t_beat queue_beat;

    // byte classification
    b37_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_valid     (front_valid),
        .i_stall     (front_stall),
        .o_beat      (front_beat)
    );

    // decoupling queue
    b37_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_stall (front_stall),
        .i_beat  (front_beat),
        .o_valid (queue_valid),
        .i_stall (queue_stall),
        .o_beat  (queue_beat)
    );

    // packing and result
    b37_back #(
        .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (queue_valid),
        .o_stall       (queue_stall),
        .i_beat        (queue_beat),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_name (o_packed_name),
        .o_kept_length (o_kept_length)
    );

endmodule
